FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside of reset
`define SCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scs assertion failed");

// consequent checked in the cycle after the antecedent
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scs next-cycle assertion failed");

`endif

FILE: design/scs_pkg.sv
`default_nettype none

package scs_pkg;

    localparam int MAX_CELLS_DEF = 16;

    localparam int CELL_W = 4;
    localparam int TIME_W = 32;
    localparam int TEX_W  = 12;
    localparam int CNT_W  = 5;
    localparam int CMD_W  = 2;
    localparam int MODE_W = 2;

    // apb port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int REG_W  = 2;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CIRC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PING   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ONCE   = 2'd3;

    localparam logic [REG_W-1:0] REG_CELL_COUNT    = 2'd0;
    localparam logic [REG_W-1:0] REG_LOOP_MODE     = 2'd1;
    localparam logic [REG_W-1:0] REG_TEXTURE_WIDTH = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] now_time;
        logic [CELL_W-1:0] cell_index;
        logic [TIME_W-1:0] delay_value;
    } t_in_word;

    typedef struct packed {
        logic              frame_updated;
        logic [TEX_W-1:0]  frame_x;
        logic [TEX_W-1:0]  frame_width;
        logic [CELL_W-1:0] cell_now;
        logic              running;
    } t_out_word;

endpackage

`default_nettype wire

FILE: design/scs_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module scs_div
    import scs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TEX_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [TEX_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(TEX_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [TEX_W-1:0]  r_quo;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign shifted = {r_rem, r_quo[TEX_W-1]};
    assign fits    = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(TEX_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo <= {r_quo[TEX_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

FILE: design/sprite_cell_sequencer_unit.sv
`default_nettype none

// sprite cell sequencer: steps through the cells of a horizontal sprite strip
// input channel (i_in_valid / o_in_ready / i_in_word): tick, delay load, restart
// output channel (o_out_valid / i_out_ready / o_out_word): exactly one word
//   per input word, in order, from an output register
// path from accept: load, restart, unknown command and disabled tick go
//   straight to the done state; a tick passes the wrap and read states,
//   and one that shows a new frame then waits in the wait state for the
//   width / count divider started at accept; a cell left above a lowered
//   count costs one subtract a cycle in the wrap state before the delay
//   read; the done state moves the result into a free output register
// one word in flight; the next word is taken the cycle after the result
//   moves into the output register
// receiver stall: the finished word holds in the output register; a second
//   result waits in the done state and the input stays not ready
// reset (i_rst_n low, synchronous): cell 0, forward, running, last change
//   time 0, cell_count 1, loop_mode 0, texture_width 0; delay memory keeps
//   its contents and must be loaded before ticks read it
// config: apb registers cell_count @0x0, loop_mode @0x4, texture_width @0x8,
//   written by the user only while the block is idle; not enforced by the block
module sprite_cell_sequencer_unit
    import scs_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int MEM_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int LIM    = (MAX_CELLS < 16) ? MAX_CELLS : 16;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WRAP = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // control state
    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_cell_count;
    logic [MODE_W-1:0] r_loop_mode;
    logic [TEX_W-1:0]  r_tex_w;
    logic [CELL_W-1:0] r_cur;
    logic              r_back;
    logic [TIME_W-1:0] r_last;
    logic              r_en;
    logic              r_out_valid;

    // payload
    logic [TIME_W-1:0] r_now;
    logic              r_upd;
    logic [TEX_W-1:0]  r_fx;
    logic [TEX_W-1:0]  r_fw;
    t_out_word         r_out;
    logic [TIME_W-1:0] r_rd_data;

    // cell delay memory, one read or one write a cycle
    logic [TIME_W-1:0] r_delay_mem [MAX_CELLS];

    logic              in_acc;
    logic              cfg_wr;
    logic              out_free;
    logic              rd_en;
    logic              load_ok;
    logic              div_start;
    logic              div_done;
    logic [TEX_W-1:0]  quot;
    logic [CNT_W-1:0]  eff_cnt;
    logic [CNT_W-1:0]  last_cell;
    logic [CNT_W-1:0]  cur_ext;
    logic              pp_dir;
    logic              dir_used;
    logic [CELL_W-1:0] step_nxt;
    logic [TIME_W-1:0] elapsed;
    logic [CELL_W+TEX_W-1:0] prod;

    assign in_acc    = i_in_valid && o_in_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign load_ok   = (i_in_word.command == CMD_LOAD)
                       && (32'(i_in_word.cell_index) < MAX_CELLS);
    assign div_start = in_acc && (i_in_word.command == CMD_TICK) && r_en;

    // cell count saturated into 1..min(16, MAX_CELLS)
    always_comb begin
        priority if (r_cell_count == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (r_cell_count > CNT_W'(LIM)) begin
            eff_cnt = CNT_W'(LIM);
        end else begin
            eff_cnt = r_cell_count;
        end
    end

    assign last_cell = eff_cnt - 1'b1;
    assign cur_ext   = {1'b0, r_cur};

    // ping-pong turns at either end before stepping
    always_comb begin
        priority if (cur_ext >= last_cell) begin
            pp_dir = 1'b1;
        end else if (r_cur == '0) begin
            pp_dir = 1'b0;
        end else begin
            pp_dir = r_back;
        end
    end

    assign dir_used = (r_loop_mode == MODE_PING) ? pp_dir : r_back;

    // cur is already below the count here, so one compare wraps it
    always_comb begin
        if (dir_used) begin
            step_nxt = (r_cur == '0) ? last_cell[CELL_W-1:0] : r_cur - 1'b1;
        end else begin
            step_nxt = (cur_ext + 1'b1 == eff_cnt) ? '0 : r_cur + 1'b1;
        end
    end

    assign elapsed = r_now - r_last;
    assign prod    = {{TEX_W{1'b0}}, r_cur} * {{CELL_W{1'b0}}, quot};
    assign rd_en   = (r_state == S_WRAP) && (cur_ext < eff_cnt);

    // texture_width / count, started with the tick
    scs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tex_w),
        .i_divisor  (eff_cnt),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= CNT_W'(1);
            r_loop_mode  <= MODE_CIRC;
            r_tex_w      <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_CELL_COUNT:    r_cell_count <= pwdata[CNT_W-1:0];
                REG_LOOP_MODE:     r_loop_mode  <= pwdata[MODE_W-1:0];
                REG_TEXTURE_WIDTH: r_tex_w      <= pwdata[TEX_W-1:0];
                default:           r_cell_count <= r_cell_count;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CELL_COUNT:    prdata = DATA_W'(r_cell_count);
            REG_LOOP_MODE:     prdata = DATA_W'(r_loop_mode);
            REG_TEXTURE_WIDTH: prdata = DATA_W'(r_tex_w);
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // sequencer and animation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_back      <= 1'b0;
            r_last      <= '0;
            r_en        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // output register loads from the done state, empties on accept
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        priority if (i_in_word.command == CMD_RESTART) begin
                            r_cur   <= '0;
                            r_back  <= 1'b0;
                            r_last  <= i_in_word.now_time;
                            r_en    <= 1'b1;
                            r_state <= S_DONE;
                        end else if (div_start) begin
                            r_state <= S_WRAP;
                        end else begin
                            // load, disabled tick, unknown command
                            r_state <= S_DONE;
                        end
                    end
                end
                S_WRAP: begin
                    // bring a stale cell back below a lowered count
                    if (cur_ext >= eff_cnt) begin
                        r_cur <= r_cur - eff_cnt[CELL_W-1:0];
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= (elapsed > r_rd_data) ? S_WAIT : S_DONE;
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_last  <= r_now;
                        r_state <= S_DONE;
                        unique case (r_loop_mode)
                            MODE_CIRC: r_cur <= step_nxt;
                            MODE_PING: begin
                                r_back <= pp_dir;
                                r_cur  <= step_nxt;
                            end
                            MODE_SINGLE: r_en <= 1'b0;
                            MODE_ONCE: begin
                                if (cur_ext < last_cell) begin
                                    r_cur <= step_nxt;
                                end else begin
                                    r_en <= 1'b0;
                                end
                            end
                            default: r_en <= r_en;
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now <= i_in_word.now_time;
            r_upd <= 1'b0;
            r_fx  <= '0;
            r_fw  <= '0;
        end
        if ((r_state == S_WAIT) && div_done) begin
            r_upd <= 1'b1;
            r_fx  <= prod[TEX_W-1:0];
            r_fw  <= quot;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out.frame_updated <= r_upd;
            r_out.frame_x       <= r_fx;
            r_out.frame_width   <= r_fw;
            r_out.cell_now      <= r_cur;
            r_out.running       <= r_en;
        end
    end

    // delay memory: write on load, registered read while wrapping
    always_ff @(posedge i_clk) begin
        if (in_acc && load_ok) begin
            r_delay_mem[MEM_AW'(i_in_word.cell_index)] <= i_in_word.delay_value;
        end
        if (rd_en) begin
            r_rd_data <= r_delay_mem[MEM_AW'(r_cur)];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

FILE: design/scs_checker.sv
`default_nettype none

`include "assert_macros.svh"

module scs_checker
    import scs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    logic out_stall;
    logic in_acc;
    logic out_no_upd;
    logic rect_clear;
    logic out_zero_w;

    assign out_stall  = o_out_valid && !i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_no_upd = o_out_valid && !o_out_word.frame_updated;
    assign rect_clear = (o_out_word.frame_x == '0) && (o_out_word.frame_width == '0);
    assign out_zero_w = o_out_valid && (o_out_word.frame_width == '0);

    // a stalled result word holds
    `SCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_word))

    // one word in flight: input closes right after an accept
    `SCS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_acc, !o_in_ready)

    // no rectangle without an update
    `SCS_ASSERT(a_no_rect, i_clk, i_rst_n, out_no_upd |-> rect_clear)

    // zero cell width means a zero offset
    `SCS_ASSERT(a_zero_width, i_clk, i_rst_n, out_zero_w |-> (o_out_word.frame_x == '0))

endmodule

bind sprite_cell_sequencer_unit scs_checker u_scs_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_sprite_cell_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_sprite_cell_sequencer_unit;
    import scs_pkg::*;

    // command code with no meaning to the block
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    // highest usable cell count
    localparam int CELL_CAP    = MAX_CELLS_DEF;
    // watchdog, far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // mismatch lines beyond this are counted but not printed
    localparam int PRINT_CAP   = 40;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_word          i_in_word = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_word         o_out_word;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    sprite_cell_sequencer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predicted animation state, a private copy kept beside the block
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] delay_tab [CELL_CAP];
    logic [CELL_W-1:0] cell_pos     = '0;
    logic              walk_back    = 1'b0;
    logic [TIME_W-1:0] last_flip_ms = '0;
    logic              anim_on      = 1'b1;

    // shadow of the config registers, follows every apb write
    logic [CNT_W-1:0]  cfg_cells = 5'd1;
    logic [MODE_W-1:0] cfg_mode  = MODE_CIRC;
    logic [TEX_W-1:0]  cfg_tex   = '0;

    t_out_word frame_expect_q[$];

    int words_sent     = 0;
    int words_checked  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // idle odds in percent per cycle for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // a long receiver hold-off is requested here and counted down below
    int hold_request  = 0;
    int hold_left     = 0;

    // one line per mismatch, printing capped
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                     what, words_checked, got, want);
        mismatch_count++;
    endtask

    // advance the predicted state by one word and build the expected result
    task automatic step_sprite(input t_in_word w, output t_out_word r);
        int unsigned       cnt;
        int unsigned       cur;
        int unsigned       nxt;
        int unsigned       per_cell;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        case (w.command)
            CMD_LOAD: begin
                delay_tab[w.cell_index] = w.delay_value;
            end
            CMD_RESTART: begin
                cell_pos     = '0;
                walk_back    = 1'b0;
                last_flip_ms = w.now_time;
                anim_on      = 1'b1;
            end
            CMD_TICK: begin
                if (anim_on) begin
                    // count register saturates into 1..16
                    cnt = 32'(cfg_cells);
                    if (cnt < 1) cnt = 1;
                    if (cnt > CELL_CAP) cnt = CELL_CAP;
                    // a cell left beyond a lowered count folds back first
                    cur      = cell_pos % cnt;
                    cell_pos = CELL_W'(cur);
                    // elapsed time wraps with the 32-bit clock
                    elapsed  = w.now_time - last_flip_ms;
                    if (elapsed > delay_tab[cell_pos]) begin
                        per_cell        = 32'(cfg_tex) / cnt;
                        last_flip_ms    = w.now_time;
                        r.frame_updated = 1'b1;
                        r.frame_x       = TEX_W'(cur * per_cell);
                        r.frame_width   = TEX_W'(per_cell);
                        // ping-pong turns at the ends before stepping
                        if (cfg_mode == MODE_PING) begin
                            if (cur >= cnt - 1) walk_back = 1'b1;
                            else if (cur == 0) walk_back = 1'b0;
                        end
                        // stepping back from cell 0 lands on the last cell
                        if (walk_back) nxt = (cur == 0) ? cnt - 1 : cur - 1;
                        else nxt = cur + 1;
                        nxt = nxt % cnt;
                        case (cfg_mode)
                            MODE_CIRC, MODE_PING: cell_pos = CELL_W'(nxt);
                            MODE_SINGLE: anim_on = 1'b0;
                            MODE_ONCE: begin
                                if (cur < cnt - 1) cell_pos = CELL_W'(nxt);
                                else anim_on = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                // unknown command leaves everything alone
            end
        endcase
        r.cell_now = cell_pos;
        r.running  = anim_on;
    endtask

    // every accepted input word gets its expected result queued
    always @(posedge i_clk) begin : input_monitor
        t_out_word frame;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            step_sprite(i_in_word, frame);
            frame_expect_q.push_back(frame);
        end
    end

    // receiver: random idling, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // every accepted output word against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_expect_q.size() == 0) begin
                flag_mismatch("unexpected word", 32'(o_out_word), '0);
            end else begin
                want = frame_expect_q.pop_front();
                if (o_out_word.frame_updated !== want.frame_updated)
                    flag_mismatch("frame_updated", 32'(o_out_word.frame_updated),
                                  32'(want.frame_updated));
                if (o_out_word.frame_x !== want.frame_x)
                    flag_mismatch("frame_x", 32'(o_out_word.frame_x), 32'(want.frame_x));
                if (o_out_word.frame_width !== want.frame_width)
                    flag_mismatch("frame_width", 32'(o_out_word.frame_width),
                                  32'(want.frame_width));
                if (o_out_word.cell_now !== want.cell_now)
                    flag_mismatch("cell_now", 32'(o_out_word.cell_now), 32'(want.cell_now));
                if (o_out_word.running !== want.running)
                    flag_mismatch("running", 32'(o_out_word.running), 32'(want.running));
                words_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d of %0d words back",
                     cycle_count, words_checked, words_sent);
            $display("** sprite_cell_sequencer_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one word, with random idle cycles ahead of it; valid stays high
    // after acceptance so back-to-back words never drop it
    task automatic drive_word(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now_ms,
                              input logic [CELL_W-1:0] idx, input logic [TIME_W-1:0] dly);
        t_in_word w;
        w.command     = cmd;
        w.now_time    = now_ms;
        w.cell_index  = idx;
        w.delay_value = dly;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        words_sent++;
    endtask

    // stop offering and wait until every word sent has come back
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (words_checked != words_sent) @(posedge i_clk);
    endtask

    // one apb transfer, setup then access; psel is left high so that
    // transfers can follow back to back
    task automatic apb_transfer(input logic wr, input logic [REG_W-1:0] idx,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        if (wr) begin
            case (idx)
                REG_CELL_COUNT:    cfg_cells = wdata[CNT_W-1:0];
                REG_LOOP_MODE:     cfg_mode  = wdata[MODE_W-1:0];
                REG_TEXTURE_WIDTH: cfg_tex   = wdata[TEX_W-1:0];
                default: ;
            endcase
        end
    endtask

    // write a register and read it back
    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] rd;
        apb_transfer(1'b1, idx, val, rd);
        apb_transfer(1'b0, idx, '0, rd);
        if (rd !== val) flag_mismatch("register readback", rd, val);
    endtask

    // new setting, only once the block has gone idle
    task automatic set_config(input logic [CNT_W-1:0] cells, input logic [MODE_W-1:0] mode,
                              input logic [TEX_W-1:0] tex);
        settle_block();
        write_reg(REG_CELL_COUNT, DATA_W'(cells));
        write_reg(REG_LOOP_MODE, DATA_W'(mode));
        write_reg(REG_TEXTURE_WIDTH, DATA_W'(tex));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // cells 0, 1, 2 and 15 are loaded here; the directed ticks read only cells 0 to 2
    task automatic test_delay_loads();
        drive_word(CMD_LOAD, 32'h0, 4'd0, 32'd5);
        drive_word(CMD_LOAD, 32'hFFFF_FFFF, 4'd1, 32'd0);
        drive_word(CMD_LOAD, 32'h0, 4'd2, 32'd3);
        drive_word(CMD_LOAD, 32'h0, 4'd15, 32'hFFFF_FFFF);
    endtask

    // elapsed equal to the delay holds, one more ms advances;
    // a restart just below the wrap point then a tick past it
    task automatic test_tick_threshold();
        set_config(5'd3, MODE_CIRC, 12'd300);
        drive_word(CMD_TICK, 32'd5, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd6, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd6, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd7, 4'd0, 32'd0);
        drive_word(CMD_RESTART, 32'hFFFF_FFF0, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'h0, 4'd0, 32'd0);
    endtask

    // ping-pong turns at the top, then circular keeps stepping back
    // and wraps from cell 0 to the last cell
    task automatic test_ping_pong_and_wrap();
        set_config(5'd3, MODE_PING, 12'd4095);
        drive_word(CMD_RESTART, 32'd100, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd200, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd300, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd400, 4'd0, 32'd0);
        set_config(5'd3, MODE_CIRC, 12'd4095);
        drive_word(CMD_TICK, 32'd500, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd600, 4'd0, 32'd0);
    endtask

    // count of 0 saturates to 1 and folds the current cell back;
    // count of 31 saturates to 16
    task automatic test_count_saturation();
        set_config(5'd0, MODE_CIRC, 12'd4095);
        drive_word(CMD_TICK, 32'd700, 4'd0, 32'd0);
        set_config(5'd31, MODE_CIRC, 12'd4095);
        drive_word(CMD_TICK, 32'd800, 4'd0, 32'd0);
    endtask

    // one frame, then the tick after it is ignored
    task automatic test_single_frame();
        set_config(5'd16, MODE_SINGLE, 12'd0);
        drive_word(CMD_RESTART, 32'd1000, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd1010, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd2000, 4'd0, 32'd0);
    endtask

    // run once stops on the last cell
    task automatic test_run_once();
        set_config(5'd2, MODE_ONCE, 12'd4095);
        drive_word(CMD_RESTART, 32'd3000, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd3010, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd3020, 4'd0, 32'd0);
        drive_word(CMD_TICK, 32'd3030, 4'd0, 32'd0);
    endtask

    task automatic test_unknown_command();
        drive_word(CMD_UNKNOWN, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
    endtask

    // mostly ticks on a rising clock with short delays, mixed with
    // reloads, restarts, odd commands and jumps of the clock;
    // twelve settings split over three idling phases
    task automatic test_random_animation(input int words_per_setting);
        logic [TIME_W-1:0] ms_clock;
        int                pick;
        int                restart_pct;
        ms_clock = $urandom;
        // fill the whole delay table before any random tick reads it
        for (int c = 0; c < CELL_CAP; c++)
            drive_word(CMD_LOAD, $urandom, CELL_W'(c), $urandom_range(40));
        for (int k = 0; k < 12; k++) begin
            if (k < 4) begin
                send_idle_pct = 22;
                recv_idle_pct = 80;
            end else if (k < 8) begin
                send_idle_pct = 80;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (k)
                0:  set_config(5'd4, MODE_CIRC, 12'd1000);
                1:  set_config(5'd16, MODE_PING, 12'd4095);
                2:  set_config(5'd1, MODE_ONCE, 12'd123);
                3:  set_config(5'd7, MODE_SINGLE, TEX_W'($urandom));
                4:  set_config(5'd0, MODE_PING, 12'd4095);
                5:  set_config(5'd31, MODE_CIRC, 12'd0);
                6:  set_config(5'd3, MODE_ONCE, TEX_W'($urandom));
                7:  set_config(5'd16, MODE_CIRC, 12'd4095);
                8:  set_config(5'd9, MODE_PING, TEX_W'($urandom));
                9:  set_config(5'd2, MODE_SINGLE, 12'd640);
                10: set_config(5'd13, MODE_ONCE, 12'd4095);
                default: set_config(5'd5, MODE_CIRC, TEX_W'($urandom));
            endcase
            // modes that stop by themselves need restarts more often
            restart_pct = (cfg_mode == MODE_SINGLE || cfg_mode == MODE_ONCE) ? 15 : 4;
            for (int n = 0; n < words_per_setting; n++) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    // mostly short delays, now and then a huge one
                    drive_word(CMD_LOAD, $urandom, CELL_W'($urandom),
                               ($urandom_range(99) < 8) ? $urandom : $urandom_range(40));
                end else if (pick < 12 + restart_pct) begin
                    drive_word(CMD_RESTART, ms_clock, CELL_W'($urandom), $urandom);
                end else if (pick < 15 + restart_pct) begin
                    drive_word(CMD_UNKNOWN, $urandom, CELL_W'($urandom), $urandom);
                end else begin
                    if ($urandom_range(99) < 2) ms_clock = $urandom;
                    else ms_clock += $urandom_range(30);
                    drive_word(CMD_TICK, ms_clock, CELL_W'($urandom), $urandom);
                end
            end
        end
    endtask

    // receiver holds off for a long stretch while ticks keep coming,
    // so the output register and the done state fill and input stalls
    task automatic test_output_backpressure();
        logic [TIME_W-1:0] ms_clock;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ms_clock      = 32'd50000;
        settle_block();
        hold_request  = 300;
        drive_word(CMD_RESTART, ms_clock, 4'd0, 32'd0);
        for (int n = 0; n < 12; n++) begin
            ms_clock += 50;
            drive_word(CMD_TICK, ms_clock, 4'd0, 32'd0);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 80;
        test_delay_loads();
        test_tick_threshold();
        test_ping_pong_and_wrap();
        test_count_saturation();
        test_single_frame();
        test_run_once();
        test_unknown_command();
        test_random_animation(120);
        test_output_backpressure();

        // drain, then a short quiet stretch to catch stray words
        settle_block();
        repeat (32) @(posedge i_clk);

        if (mismatch_count == 0 && frame_expect_q.size() == 0)
            $display("** sprite_cell_sequencer_unit: PASSED **");
        else
            $display("** sprite_cell_sequencer_unit: FAILED **");
        $finish;
    end

endmodule
